/* design/hall_switch_hold_gesture_detector_assert.svh */
// Assertion macros shared by the hall switch hold detector RTL.
`ifndef HALL_SWITCH_HOLD_GESTURE_DETECTOR_ASSERT_SVH
`define HALL_SWITCH_HOLD_GESTURE_DETECTOR_ASSERT_SVH

// Clocked assertion with synchronous active-low reset as disable condition.
`define HSGD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same, but also checked while reset is asserted.
`define HSGD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* design/hsgd_pkg.sv */
// Package: types and constants for the hall switch hold detector.
package hsgd_pkg;

  localparam int unsigned TIME_W = 32;
  localparam int unsigned CFG_W  = 16;
  localparam int unsigned CFG_IDX_W = 2;

  typedef logic [TIME_W-1:0] time_ms_t;
  typedef logic [CFG_W-1:0]  cfg_ms_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STABLE       = 2'd0,
    CFG_SHORT_HOLD   = 2'd1,
    CFG_LONG_HOLD    = 2'd2,
    CFG_IGNORE_START = 2'd3
  } cfg_idx_t;

  localparam logic OP_POLL = 1'b0;
  localparam logic OP_INIT = 1'b1;

  localparam cfg_ms_t STABLE_MS_RST       = 16'd20;
  localparam cfg_ms_t SHORT_HOLD_MS_RST   = 16'd1000;
  localparam cfg_ms_t LONG_HOLD_MS_RST    = 16'd4000;
  localparam cfg_ms_t IGNORE_START_MS_RST = 16'd1500;

  typedef struct packed {
    logic request_start;
    logic request_config;
    logic clear_wake;
    logic switch_active;
  } result_t;

endpackage

/* design/hall_switch_hold_gesture_detector.sv */
// Top level: debounced hold and release detector for a magnet switch.
//
// Accepts one transaction per clock while out_ready lets results drain; each
// poll or init passes an input register, one pass of compare logic (three
// 32-bit wrapping subtracts checked against 16-bit thresholds) and lands in
// the result register, so the sustained rate is one item per cycle when
// out_ready stays high. The output register lets a new item enter while a
// finished result waits for out_ready. Configuration writes take effect on
// the next clock and must be made while no transaction is in flight.
`include "hall_switch_hold_gesture_detector_assert.svh"

module hall_switch_hold_gesture_detector (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_opcode,
  input  logic [hsgd_pkg::TIME_W-1:0]     in_now_ms,
  input  logic                            in_pin_level,
  input  logic                            in_mode_is_idle,
  input  logic                            in_woke_flag,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_request_start,
  output logic                            out_request_config,
  output logic                            out_clear_wake,
  output logic                            out_switch_active,
  input  logic                            cfg_we,
  input  logic [hsgd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hsgd_pkg::CFG_W-1:0]      cfg_wdata
);

  // configuration
  hsgd_pkg::cfg_ms_t stable_ms_r, short_hold_ms_r, long_hold_ms_r, ignore_ms_r;

  // input stage
  logic               s1_valid_r;
  logic               s1_opcode_r;
  hsgd_pkg::time_ms_t s1_now_r;
  logic               s1_pin_r;
  logic               s1_idle_r;
  logic               s1_woke_r;

  // detector state
  hsgd_pkg::time_ms_t start_time_r, start_time_nxt;
  hsgd_pkg::time_ms_t press_time_r, press_time_nxt;
  hsgd_pkg::time_ms_t change_since_r, change_since_nxt;
  logic long_done_r, long_done_nxt;
  logic await_r, await_nxt;
  logic qa_r, qa_nxt;
  logic prev_r, prev_nxt;
  logic ct_r, ct_nxt;

  // result stage
  logic              out_valid_r;
  hsgd_pkg::result_t res_r, res_nxt;

  logic s1_adv;
  logic out_free;

  assign out_free = !out_valid_r || out_ready;
  assign s1_adv   = s1_valid_r && out_free;
  assign in_ready = !s1_valid_r || s1_adv;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stable_ms_r     <= hsgd_pkg::STABLE_MS_RST;
      short_hold_ms_r <= hsgd_pkg::SHORT_HOLD_MS_RST;
      long_hold_ms_r  <= hsgd_pkg::LONG_HOLD_MS_RST;
      ignore_ms_r     <= hsgd_pkg::IGNORE_START_MS_RST;
    end else if (cfg_we) begin
      unique case (hsgd_pkg::cfg_idx_t'(cfg_index))
        hsgd_pkg::CFG_STABLE:       stable_ms_r     <= cfg_wdata;
        hsgd_pkg::CFG_SHORT_HOLD:   short_hold_ms_r <= cfg_wdata;
        hsgd_pkg::CFG_LONG_HOLD:    long_hold_ms_r  <= cfg_wdata;
        hsgd_pkg::CFG_IGNORE_START: ignore_ms_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_opcode_r <= in_opcode;
      s1_now_r    <= in_now_ms;
      s1_pin_r    <= in_pin_level;
      s1_idle_r   <= in_mode_is_idle;
      s1_woke_r   <= in_woke_flag;
    end
  end

  // single-pass update
  hsgd_pkg::time_ms_t eff_start, since_start, since_change, press_eff, held;
  logic raw_active, new_press, ld_eff;

  always_comb begin
    start_time_nxt   = start_time_r;
    press_time_nxt   = press_time_r;
    change_since_nxt = change_since_r;
    long_done_nxt    = long_done_r;
    await_nxt        = await_r;
    qa_nxt           = qa_r;
    prev_nxt         = prev_r;
    ct_nxt           = ct_r;
    res_nxt          = '0;

    eff_start    = await_r ? s1_now_r : start_time_r;
    since_start  = s1_now_r - eff_start;
    since_change = s1_now_r - change_since_r;
    raw_active   = !s1_pin_r;
    new_press    = 1'b0;
    press_eff    = press_time_r;
    ld_eff       = long_done_r;
    held         = '0;

    if (s1_opcode_r == hsgd_pkg::OP_INIT) begin
      start_time_nxt = s1_now_r;
      if (s1_woke_r) begin
        await_nxt      = 1'b1;
        press_time_nxt = '0;
        long_done_nxt  = 1'b0;
      end
    end else if (!(await_r && !s1_pin_r)) begin
      // a released pin ends the post-wake wait and restarts the window
      if (await_r) begin
        await_nxt          = 1'b0;
        res_nxt.clear_wake = 1'b1;
        start_time_nxt     = s1_now_r;
      end
      if (since_start >= {{(hsgd_pkg::TIME_W-hsgd_pkg::CFG_W){1'b0}}, ignore_ms_r}) begin
        if (raw_active != qa_r) begin
          if (!ct_r) begin
            ct_nxt           = 1'b1;
            change_since_nxt = s1_now_r;
          end else if (since_change >=
                       {{(hsgd_pkg::TIME_W-hsgd_pkg::CFG_W){1'b0}}, stable_ms_r}) begin
            qa_nxt = raw_active;
            ct_nxt = 1'b0;
          end
        end else begin
          ct_nxt = 1'b0;
        end

        new_press = qa_nxt && !prev_r;
        press_eff = new_press ? s1_now_r : press_time_r;
        ld_eff    = new_press ? 1'b0 : long_done_r;
        held      = s1_now_r - press_eff;
        press_time_nxt = press_eff;
        long_done_nxt  = ld_eff;

        if (qa_nxt && !ld_eff &&
            held >= {{(hsgd_pkg::TIME_W-hsgd_pkg::CFG_W){1'b0}}, long_hold_ms_r}) begin
          long_done_nxt          = 1'b1;
          res_nxt.request_config = s1_idle_r;
        end
        if (!qa_nxt && prev_r && !ld_eff && s1_idle_r &&
            held >= {{(hsgd_pkg::TIME_W-hsgd_pkg::CFG_W){1'b0}}, short_hold_ms_r}) begin
          res_nxt.request_start = 1'b1;
        end
        prev_nxt = qa_nxt;
      end
    end
    res_nxt.switch_active = qa_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_time_r   <= '0;
      press_time_r   <= '0;
      change_since_r <= '0;
      long_done_r    <= 1'b0;
      await_r        <= 1'b0;
      qa_r           <= 1'b0;
      prev_r         <= 1'b0;
      ct_r           <= 1'b0;
    end else if (s1_adv) begin
      start_time_r   <= start_time_nxt;
      press_time_r   <= press_time_nxt;
      change_since_r <= change_since_nxt;
      long_done_r    <= long_done_nxt;
      await_r        <= await_nxt;
      qa_r           <= qa_nxt;
      prev_r         <= prev_nxt;
      ct_r           <= ct_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_request_start  = res_r.request_start;
  assign out_request_config = res_r.request_config;
  assign out_clear_wake     = res_r.clear_wake;
  assign out_switch_active  = res_r.switch_active;

  // checks
  `HSGD_ASSERT(a_req_matches_state,
    out_valid_r |-> (!res_r.request_config || res_r.switch_active) &&
                    (!res_r.request_start || !res_r.switch_active),
    "request does not match qualified switch state")
  `HSGD_ASSERT(a_init_no_request,
    (s1_adv && s1_opcode_r == hsgd_pkg::OP_INIT) |=>
      out_valid_r && !res_r.request_start && !res_r.request_config && !res_r.clear_wake,
    "init transaction produced a request")
  `HSGD_ASSERT(a_wake_release_clears,
    (s1_adv && s1_opcode_r == hsgd_pkg::OP_POLL && await_r && s1_pin_r) |=>
      !await_r && res_r.clear_wake,
    "wake release did not clear the wait")
  `HSGD_ASSERT_ALWAYS(a_reset_empty,
    !rst_n |=> !out_valid_r && !s1_valid_r,
    "pipeline not empty after reset")

endmodule
